/* rtl/core/ack_retransmit_tracker_top_assert.svh */
// Assertion macros used by the retransmission tracker top level.
`ifndef ACK_RETRANSMIT_TRACKER_TOP_ASSERT_SVH
`define ACK_RETRANSMIT_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define ART_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define ART_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/art_pkg.sv */
// Shared constants and types of the retransmission tracker.
package art_pkg;

   localparam int ENTRIES = 16;
   localparam int SEQ_W = 32;
   localparam int AGE_W = 8;
   localparam int KIND_W = 3;
   localparam int REQ_W = 2;
   localparam int STEP_W = $clog2(ENTRIES + 1);

   localparam logic [REQ_W-1:0] REQ_SEND = 2'd0;
   localparam logic [REQ_W-1:0] REQ_ACK = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ASSIGNED = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FULL = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ACK_CLEARED = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ACK_UNKNOWN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESEND = 3'd4;
   localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd5;

   localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
   localparam logic [AGE_W-1:0] TIMEOUT_RESET = 8'd3;
   localparam logic [SEQ_W-1:0] SEQ_RESET = 32'd1;

   typedef struct packed {
      logic valid;
      logic [SEQ_W-1:0] seq;
      logic [AGE_W-1:0] age;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic clear;
      logic [SEQ_W-1:0] key;
   } cmd_type;

endpackage

/* rtl/core/ack_retransmit_tracker_top.sv */
// Top level of the sender-side retransmission tracker.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// req_type selects send, ack or tick; req_ack_seq carries the number of an ack.
// Results appear on the rsp_ ports for one cycle each, marked by rsp_valid,
// and cannot be held off. rsp_last marks the final result of an item.
// A send or an ack gives its single result in the cycle after acceptance and
// busy stays low, so such items can be issued every cycle.
// A tick raises busy while the sixteen table cells rotate through the
// aging unit at the head of the chain, one entry per cycle, so each timed-out
// entry gives a resend result in the cycle after its turn. The tick-done result
// is on the ports when busy is low again and the next item may be accepted.
// The timeout register is written through csr_valid/csr_ready whenever no
// tick is running. Request type three is accepted and ignored.
// Synchronous reset empties the table, sets the next sequence number to one
// and the timeout to three ticks.
module ack_retransmit_tracker_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [art_pkg::REQ_W-1:0]   req_type,
   input  logic [art_pkg::SEQ_W-1:0]   req_ack_seq,
   output logic                        rsp_valid,
   output logic [art_pkg::KIND_W-1:0]  rsp_result_kind,
   output logic [art_pkg::SEQ_W-1:0]   rsp_seq,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [art_pkg::AGE_W-1:0]   csr_timeout_ticks
);
   import art_pkg::*;
   `include "ack_retransmit_tracker_top_assert.svh"

   typedef enum logic {ST_IDLE, ST_TICK} state_type;

   state_type state_ff;
   logic [STEP_W-1:0] step_ff;
   logic [SEQ_W-1:0] next_seq_ff;
   logic [AGE_W-1:0] timeout_ff;
   logic rsp_valid_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [SEQ_W-1:0] rsp_seq_ff;
   logic rsp_last_ff;

   entry_type entries [ENTRIES];
   entry_type aged;
   logic [ENTRIES-1:0] match_vec, free_vec, match_oh, free_oh, sel;
   logic accept, is_send, is_ack, shifting, timed_out, full;
   logic [AGE_W-1:0] age_inc;
   cmd_type cmd;

   assign accept = start && (state_ff == ST_IDLE);
   assign is_send = accept && (req_type == REQ_SEND);
   assign is_ack = accept && (req_type == REQ_ACK);
   assign shifting = (state_ff == ST_TICK) && (step_ff != STEP_W'(ENTRIES));

   assign match_oh = match_vec & ENTRIES'(~match_vec + ENTRIES'(1));
   assign free_oh = free_vec & ENTRIES'(~free_vec + ENTRIES'(1));
   assign sel = (is_send && (match_vec == '0)) ? free_oh : match_oh;
   assign full = (sel == '0);

   always_comb begin
      cmd.shift = shifting;
      cmd.load = is_send;
      cmd.clear = is_ack;
      cmd.key = (req_type == REQ_SEND) ? next_seq_ff : req_ack_seq;
   end

   assign age_inc = (entries[0].age == AGE_MAX) ? entries[0].age
                    : entries[0].age + AGE_W'(1);
   assign timed_out = entries[0].valid && (age_inc > timeout_ff);
   assign aged = '{valid: entries[0].valid, seq: entries[0].seq,
                   age: (timed_out ? '0 : age_inc)};

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type neighbor;
      if (i == ENTRIES - 1) begin : g_tail
         assign neighbor = aged;
      end else begin : g_body
         assign neighbor = entries[i + 1];
      end
      art_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .sel      (sel[i]),
         .neighbor (neighbor),
         .entry    (entries[i]),
         .match    (match_vec[i])
      );
      assign free_vec[i] = !entries[i].valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         next_seq_ff <= SEQ_RESET;
         timeout_ff <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
         rsp_kind_ff <= KIND_ASSIGNED;
         rsp_seq_ff <= '0;
         rsp_last_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_timeout_ticks;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_type)
                     REQ_SEND: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_last_ff <= 1'b1;
                        if (full) begin
                           rsp_kind_ff <= KIND_FULL;
                           rsp_seq_ff <= '0;
                        end else begin
                           rsp_kind_ff <= KIND_ASSIGNED;
                           rsp_seq_ff <= next_seq_ff;
                           next_seq_ff <= next_seq_ff + SEQ_W'(1);
                        end
                     end
                     REQ_ACK: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_last_ff <= 1'b1;
                        rsp_seq_ff <= req_ack_seq;
                        rsp_kind_ff <= full ? KIND_ACK_UNKNOWN : KIND_ACK_CLEARED;
                     end
                     REQ_TICK: begin
                        state_ff <= ST_TICK;
                        step_ff <= '0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_TICK: begin
               if (shifting) begin
                  step_ff <= step_ff + STEP_W'(1);
                  if (timed_out) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff <= KIND_RESEND;
                     rsp_seq_ff <= entries[0].seq;
                     rsp_last_ff <= 1'b0;
                  end
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff <= KIND_TICK_DONE;
                  rsp_seq_ff <= '0;
                  rsp_last_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy = (state_ff == ST_TICK);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_seq = rsp_seq_ff;
   assign rsp_last = rsp_last_ff;

   `ART_ASSERT_NEXT(a_tick_goes_busy, clock, reset, accept && (req_type == REQ_TICK), busy, "tick item did not start the scan")
   `ART_ASSERT_NEXT(a_tick_ends_done, clock, reset, busy && !shifting, !busy && rsp_valid && rsp_last && (rsp_result_kind == KIND_TICK_DONE), "tick scan did not end with tick done")
   `ART_ASSERT_IMPLY(a_resend_in_scan, clock, reset, rsp_valid && !rsp_last, busy && (rsp_result_kind == KIND_RESEND), "non-final result outside a tick scan")
   `ART_ASSERT_IMPLY(a_one_cell_selected, clock, reset, 1'b1, $onehot0(sel), "more than one table cell selected")

endmodule

/* rtl/core/art_cell.sv */
// One pending-table cell: holds an entry, matches a key and takes its neighbor's entry on a shift.
module art_cell (
   input  logic              clock,
   input  logic              reset,
   input  art_pkg::cmd_type   cmd,
   input  logic              sel,
   input  art_pkg::entry_type neighbor,
   output art_pkg::entry_type entry,
   output logic              match
);
   import art_pkg::*;

   logic valid_ff, valid_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [AGE_W-1:0] age_ff, age_in;

   always_comb begin
      valid_in = valid_ff;
      seq_in = seq_ff;
      age_in = age_ff;
      if (cmd.shift) begin
         valid_in = neighbor.valid;
         seq_in = neighbor.seq;
         age_in = neighbor.age;
      end else if (sel && cmd.load) begin
         valid_in = 1'b1;
         seq_in = cmd.key;
         age_in = '0;
      end else if (sel && cmd.clear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      seq_ff <= seq_in;
      age_ff <= age_in;
   end

   assign entry = '{valid: valid_ff, seq: seq_ff, age: age_ff};
   assign match = valid_ff && (seq_ff == cmd.key);

endmodule
